/* sv/rbd_pkg.sv */
`timescale 1ns / 1ps
package rbd_pkg;

    // Default table sizes.
    localparam int MAX_LINES_DEF = 16;
    localparam int MAX_PTS_DEF   = 16;

    // Request kinds.
    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_ADD    = 2'd1,
        ACT_ADD_PT = 2'd2,
        ACT_DEMUX  = 2'd3
    } t_action;

    // Demultiplexing method codes.
    localparam logic [1:0] METH_NONE = 2'd0;
    localparam logic [1:0] METH_MID  = 2'd1;
    localparam logic [1:0] METH_SSRC = 2'd2;
    localparam logic [1:0] METH_PT   = 2'd3;

    // Register addresses, as compared with paddr.
    localparam logic [0:0] REG_BUNDLE_ACCEPTED = 1'b0;

    // One classified request as it travels from front to back.
    typedef struct packed {
        t_action     action;
        logic [3:0]  slot;
        logic [7:0]  mline_number;
        logic [63:0] mid_key;
        logic        rejected;
        logic        in_bundle;
        logic [31:0] ssrc;
        logic [6:0]  payload_type;
    } t_req;

    // One result.
    typedef struct packed {
        logic        status;
        logic [1:0]  demux_method;
        logic [3:0]  match_slot;
        logic [7:0]  match_mline_number;
    } t_res;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LEARN,
        ST_DONE
    } t_state;

endpackage

/* sv/rbd_front.sv */
`timescale 1ns / 1ps
// Accepts requests and holds them in a two-entry queue.
module rbd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  rbd_pkg::t_req i_req,
    output logic          o_valid,
    output rbd_pkg::t_req o_req,
    input  logic          i_take
);
    rbd_pkg::t_req r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd;
    logic       r_wr;
    logic       w_in;
    logic       w_out;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_req   = r_q[r_rd];
    assign w_in    = i_push && !o_full;
    assign w_out   = i_take && o_valid;

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_in) begin
            r_q[r_wr] <= i_req;
        end
    end

    // Queue pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (w_in) begin
                r_wr <= ~r_wr;
            end
            if (w_out) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, w_in} - {1'b0, w_out};
        end
    end
endmodule

/* sv/rbd_back.sv */
`timescale 1ns / 1ps
// Carries out requests against the line table, one entry per scan cycle.
module rbd_back #(
    parameter int MAX_LINES = rbd_pkg::MAX_LINES_DEF,
    parameter int MAX_PTS   = rbd_pkg::MAX_PTS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_bundle_accepted,
    input  logic          i_valid,
    input  rbd_pkg::t_req i_req,
    output logic          o_take,
    output logic          o_res_valid,
    output rbd_pkg::t_res o_res,
    input  logic          i_res_take
);
    localparam int LW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int CW = $clog2(MAX_LINES + 1);
    localparam int PW = (MAX_PTS > 1) ? $clog2(MAX_PTS) : 1;
    localparam int NW = $clog2(MAX_PTS + 1);

    // Per-entry registers; each is read at a scan index or the request slot.
    // A whole payload list is one word, so the list store is one entry per line.
    logic [63:0]             r_mid   [MAX_LINES];
    logic [7:0]              r_line  [MAX_LINES];
    logic                    r_elig  [MAX_LINES];
    logic [31:0]             r_ssrc  [MAX_LINES];
    logic [NW-1:0]           r_ptn   [MAX_LINES];
    logic [MAX_PTS-1:0][6:0] r_pts   [MAX_LINES];
    logic [CW-1:0]           r_count;

    rbd_pkg::t_state r_state, n_state;
    rbd_pkg::t_req   r_req;
    logic [CW-1:0]   r_idx, n_idx;
    logic            r_found, n_found;
    logic [1:0]      r_hits, n_hits;
    logic [LW-1:0]   r_sel, n_sel;
    logic [1:0]      r_meth, n_meth;
    logic            r_conflict, n_conflict;
    logic            r_out_v;
    rbd_pkg::t_res   r_res, n_res;

    logic [LW-1:0] w_i;
    logic          w_pt_hit;
    logic          w_dup;
    logic          w_scan_end;
    logic          w_fin;
    logic [LW-1:0] w_slot;

    assign w_i      = r_idx[LW-1:0];
    assign w_slot   = LW'(r_req.slot);
    assign o_take   = (r_state == rbd_pkg::ST_IDLE) && !r_out_v;
    assign o_res_valid = r_out_v;
    assign o_res    = r_res;

    // Does entry w_i hold the payload type: a parallel compare over its list.
    always_comb begin
        w_pt_hit = 1'b0;
        for (int j = 0; j < MAX_PTS; j++) begin
            if (NW'(j) < r_ptn[w_i] && r_pts[w_i][j] == r_req.payload_type) begin
                w_pt_hit = 1'b1;
            end
        end
    end

    // Does the addressed slot already hold the payload type being added.
    always_comb begin
        w_dup = 1'b0;
        for (int j = 0; j < MAX_PTS; j++) begin
            if (NW'(j) < r_ptn[w_slot] && r_pts[w_slot][j] == r_req.payload_type) begin
                w_dup = 1'b1;
            end
        end
    end

    assign w_scan_end = (r_idx + CW'(1) >= r_count);

    // Sequencer: next state, scan bookkeeping and result.
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_found    = r_found;
        n_hits     = r_hits;
        n_sel      = r_sel;
        n_meth     = r_meth;
        n_conflict = r_conflict;
        n_res      = r_res;
        w_fin      = 1'b0;
        case (r_state)
            rbd_pkg::ST_IDLE: begin
                if (i_valid && !r_out_v) begin
                    n_idx      = '0;
                    n_found    = 1'b0;
                    n_hits     = 2'd0;
                    n_sel      = '0;
                    n_meth     = rbd_pkg::METH_NONE;
                    n_conflict = 1'b0;
                    n_state    = rbd_pkg::ST_SCAN;
                end
            end
            rbd_pkg::ST_SCAN: begin
                n_res = '0;
                case (r_req.action)
                    rbd_pkg::ACT_CLEAR: begin
                        n_state = rbd_pkg::ST_DONE;
                    end
                    rbd_pkg::ACT_ADD: begin
                        if (r_count >= CW'(MAX_LINES)) begin
                            n_res.status = 1'b1;
                        end else begin
                            n_res.match_slot         = 4'(r_count);
                            n_res.match_mline_number = r_req.mline_number;
                        end
                        n_state = rbd_pkg::ST_DONE;
                    end
                    rbd_pkg::ACT_ADD_PT: begin
                        n_state = rbd_pkg::ST_DONE;
                        if (CW'(r_req.slot) >= r_count || 32'(r_req.slot) >= MAX_LINES) begin
                            n_res.status = 1'b1;
                        end else if (w_dup) begin
                            n_res.match_slot         = r_req.slot;
                            n_res.match_mline_number = r_line[w_slot];
                        end else if (r_ptn[w_slot] >= NW'(MAX_PTS)) begin
                            n_res.status = 1'b1;
                        end else begin
                            n_res.match_slot         = r_req.slot;
                            n_res.match_mline_number = r_line[w_slot];
                        end
                    end
                    default: begin
                        // Demux: one entry per cycle; the MID match if a MID key is given, else the SSRC/PT match.
                        if (!i_bundle_accepted || r_count == '0) begin
                            n_res.status = 1'b1;
                            n_state = rbd_pkg::ST_DONE;
                        end else begin
                            if (r_req.mid_key != 64'd0) begin
                                if (!r_found && r_mid[w_i] == r_req.mid_key) begin
                                    n_found = 1'b1;
                                    n_sel   = w_i;
                                    n_meth  = r_elig[w_i] ? rbd_pkg::METH_MID
                                                          : rbd_pkg::METH_NONE;
                                end
                            end else if (r_meth != rbd_pkg::METH_SSRC) begin
                                if (r_req.ssrc != 32'd0 && r_elig[w_i]
                                    && r_ssrc[w_i] == r_req.ssrc) begin
                                    n_meth = rbd_pkg::METH_SSRC;
                                    n_sel  = w_i;
                                end else if (r_elig[w_i] && w_pt_hit) begin
                                    if (r_hits != 2'd2) begin
                                        n_hits = r_hits + 2'd1;
                                    end
                                    if (r_hits == 2'd0) begin
                                        n_sel = w_i;
                                    end
                                end
                            end
                            n_idx = r_idx + CW'(1);
                            if (w_scan_end) begin
                                n_idx = '0;
                                if (r_req.mid_key == 64'd0 && r_meth != rbd_pkg::METH_SSRC
                                    && !(r_req.ssrc != 32'd0 && r_elig[w_i]
                                         && r_ssrc[w_i] == r_req.ssrc)) begin
                                    if (n_hits == 2'd1) begin
                                        n_meth = rbd_pkg::METH_PT;
                                    end
                                end
                                n_state = rbd_pkg::ST_LEARN;
                            end
                        end
                    end
                endcase
            end
            rbd_pkg::ST_LEARN: begin
                // Second pass: look for another eligible entry with this SSRC.
                if (r_meth == rbd_pkg::METH_NONE || r_meth == rbd_pkg::METH_SSRC
                    || r_req.ssrc == 32'd0) begin
                    n_state = rbd_pkg::ST_DONE;
                end else begin
                    if (w_i != r_sel && r_elig[w_i] && r_ssrc[w_i] == r_req.ssrc) begin
                        n_conflict = 1'b1;
                    end
                    n_idx = r_idx + CW'(1);
                    if (w_scan_end) begin
                        n_state = rbd_pkg::ST_DONE;
                    end
                end
                if (n_state == rbd_pkg::ST_DONE) begin
                    if (r_meth == rbd_pkg::METH_NONE || n_conflict
                        || (r_req.ssrc != 32'd0 && r_meth != rbd_pkg::METH_SSRC
                            && r_ssrc[r_sel] != 32'd0 && r_ssrc[r_sel] != r_req.ssrc)) begin
                        n_res.status = 1'b1;
                    end else begin
                        n_res.demux_method       = r_meth;
                        n_res.match_slot         = 4'(r_sel);
                        n_res.match_mline_number = r_line[r_sel];
                    end
                end
            end
            rbd_pkg::ST_DONE: begin
                w_fin   = 1'b1;
                n_state = rbd_pkg::ST_IDLE;
            end
            default: begin
                n_state = rbd_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rbd_pkg::ST_IDLE;
            r_out_v <= 1'b0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (w_fin) begin
                r_out_v <= 1'b1;
            end else if (i_res_take) begin
                r_out_v <= 1'b0;
            end
            if (w_fin && r_req.action == rbd_pkg::ACT_CLEAR) begin
                r_count <= '0;
            end else if (w_fin && r_req.action == rbd_pkg::ACT_ADD && !r_res.status) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    // Working registers and the table itself.
    always_ff @(posedge i_clk) begin
        if (r_state == rbd_pkg::ST_IDLE && i_valid && !r_out_v) begin
            r_req <= i_req;
        end
        r_idx      <= n_idx;
        r_found    <= n_found;
        r_hits     <= n_hits;
        r_sel      <= n_sel;
        r_meth     <= n_meth;
        r_conflict <= n_conflict;
        r_res      <= n_res;
        if (w_fin && !r_res.status) begin
            case (r_req.action)
                rbd_pkg::ACT_ADD: begin
                    r_mid [r_count[LW-1:0]] <= r_req.mid_key;
                    r_line[r_count[LW-1:0]] <= r_req.mline_number;
                    r_elig[r_count[LW-1:0]] <= r_req.in_bundle && !r_req.rejected;
                    r_ssrc[r_count[LW-1:0]] <= 32'd0;
                    r_ptn [r_count[LW-1:0]] <= '0;
                end
                rbd_pkg::ACT_ADD_PT: begin
                    if (!w_dup) begin
                        r_pts[w_slot][r_ptn[w_slot][PW-1:0]] <= r_req.payload_type;
                        r_ptn[w_slot] <= r_ptn[w_slot] + NW'(1);
                    end
                end
                rbd_pkg::ACT_DEMUX: begin
                    if (r_req.ssrc != 32'd0) begin
                        r_ssrc[r_sel] <= r_req.ssrc;
                    end
                end
                default: begin
                end
            endcase
        end
    end
endmodule

/* sv/rtp_bundle_demux.sv */
`timescale 1ns / 1ps
// Channel  | Handshake          | Payload
// input    | push / full        | action, slot, mline_number, mid_key, port, bonly,
//          |                    | in_bundle, ssrc, payload_type
// result   | empty / pop        | status, demux_method, match_slot, match_mline_number
// config   | APB psel..pready   | bundle_accepted at address 0
// For a demux request the back end walks the entry registers once to match and once to
// check SSRC learning. Reset is synchronous and empties the table. The front queue
// holds two requests while the back end or the result stalls.
module rtp_bundle_demux #(
    parameter int MAX_LINES = rbd_pkg::MAX_LINES_DEF,
    parameter int MAX_PTS   = rbd_pkg::MAX_PTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_action,
    input  logic [3:0]  i_slot,
    input  logic [7:0]  i_mline_number,
    input  logic [63:0] i_mid_key,
    input  logic [15:0] i_port,
    input  logic        i_bonly,
    input  logic        i_in_bundle,
    input  logic [31:0] i_ssrc,
    input  logic [6:0]  i_payload_type,
    output logic        empty,
    input  logic        pop,
    output logic        o_status,
    output logic [1:0]  o_demux_method,
    output logic [3:0]  o_match_slot,
    output logic [7:0]  o_match_mline_number,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    rbd_pkg::t_req w_in_req;
    rbd_pkg::t_req w_q_req;
    rbd_pkg::t_res w_res;
    logic          w_q_valid;
    logic          w_take;
    logic          w_res_valid;
    logic          r_bundle_accepted;

    // Configuration register.
    assign pready = 1'b1;
    assign prdata = {31'd0, r_bundle_accepted};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bundle_accepted <= 1'b0;
        end else if (psel && penable && pwrite && paddr == rbd_pkg::REG_BUNDLE_ACCEPTED) begin
            r_bundle_accepted <= pwdata[0];
        end
    end

    // Classify the request on entry.
    always_comb begin
        w_in_req.action       = rbd_pkg::t_action'(i_action);
        w_in_req.slot         = i_slot;
        w_in_req.mline_number = i_mline_number;
        w_in_req.mid_key      = i_mid_key;
        w_in_req.rejected     = (i_port == 16'd0) && !i_bonly;
        w_in_req.in_bundle    = i_in_bundle;
        w_in_req.ssrc         = i_ssrc;
        w_in_req.payload_type = i_payload_type;
    end

    rbd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_req   (w_in_req),
        .o_valid (w_q_valid),
        .o_req   (w_q_req),
        .i_take  (w_take)
    );

    rbd_back #(
        .MAX_LINES (MAX_LINES),
        .MAX_PTS   (MAX_PTS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_bundle_accepted (r_bundle_accepted),
        .i_valid           (w_q_valid),
        .i_req             (w_q_req),
        .o_take            (w_take),
        .o_res_valid       (w_res_valid),
        .o_res             (w_res),
        .i_res_take        (pop)
    );

    assign empty                = !w_res_valid;
    assign o_status             = w_res.status;
    assign o_demux_method       = w_res.demux_method;
    assign o_match_slot         = w_res.match_slot;
    assign o_match_mline_number = w_res.match_mline_number;
endmodule
